[hdl/mmrp_pkg.sv]
// Package of the MSHR merge region prefetcher: types, codes, constants, throttle function.
// Used by the interfaces, the controller, the datapath and the top level.
package mmrp_pkg;

	// Default values of the top-level parameters.
	localparam int unsigned TABLE_ENTRIES_DEF = 16;
	localparam int unsigned LINE_SHIFT_DEF    = 6;
	localparam int unsigned REGION_SHIFT_DEF  = 8;
	localparam int unsigned MAX_DEGREE_DEF    = 64;

	// Field widths.
	localparam int unsigned ADDR_W   = 48;
	localparam int unsigned TAG_W    = 40;
	localparam int unsigned LINE_W   = 42;
	localparam int unsigned STAMP_W  = 32;
	localparam int unsigned CNT_W    = 16;
	localparam int unsigned MERGE_W  = 8;
	localparam int unsigned OCC_W    = 9;
	localparam int unsigned SLOT_W   = 7;
	localparam int unsigned RUN_W    = 7;
	localparam int unsigned QTR_W    = 3;
	localparam int unsigned QUOT_W   = 12;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 9;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_MSHR_CAPACITY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH_ENABLE = 1'd1;
	localparam logic [CFG_DATA_W-1:0] MSHR_CAPACITY_RST  = 9'd32;

	// Training thresholds.
	localparam logic [MERGE_W-1:0] MERGE_ARM  = 8'd3;
	localparam logic [CNT_W-1:0]   MERGE_LOW  = 16'd100;
	localparam logic [CNT_W-1:0]   MERGE_HIGH = 16'd200;
	localparam logic [CNT_W-1:0]   CNT_MAX    = 16'hFFFF;

	// Division by 25 as multiply by reciprocal: exact for every 16-bit value.
	localparam logic [16:0] DIV25_MUL   = 17'd83887;
	localparam int unsigned DIV25_SHIFT = 21;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_DIVIDE,
		ST_SIZE,
		ST_EMIT
	} state_t;

	// What the event did to the table, which selects the run formula.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_NEW_MISS,
		KIND_KNOWN_MISS
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
		logic divide;
		logic size;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic enabled;
		logic scan_done;
		logic emit_done;
	} sts_t;

	// One region table entry as stored in memory.
	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
		logic [CNT_W-1:0]   merge_total;
		logic [CNT_W-1:0]   hit_total;
		logic [CNT_W-1:0]   miss_total;
	} entry_t;

	// Occupancy throttle in quarters; a capacity of zero counts as one.
	function automatic logic [QTR_W-1:0] throttle_quarters(
		input logic [OCC_W-1:0] in_use,
		input logic [OCC_W-1:0] capacity
	);
		logic [OCC_W-1:0] cap;
		logic [13:0]      u10;
		cap = (capacity == '0) ? OCC_W'(1) : capacity;
		u10 = 14'(in_use) * 14'd10;
		if (in_use >= cap)                  return 3'd0;
		else if (u10 >= 14'(cap) * 14'd9)   return 3'd1;
		else if (u10 >= 14'(cap) * 14'd8)   return 3'd2;
		else if (u10 >= 14'(cap) * 14'd7)   return 3'd3;
		else                                return 3'd4;
	endfunction

endpackage

[hdl/mmrp_evt_if.sv]
// Training event channel of the MSHR merge region prefetcher.
// Depends on mmrp_pkg for the field widths.
interface mmrp_evt_if;
	logic                           valid;
	logic                           ready;
	logic [mmrp_pkg::ADDR_W-1:0]    access_addr;
	logic                           cache_hit;
	logic [mmrp_pkg::MERGE_W-1:0]   merged_requests;
	logic [mmrp_pkg::OCC_W-1:0]     mshr_in_use;
	logic [mmrp_pkg::SLOT_W-1:0]    queue_slots;

	modport source (output valid, access_addr, cache_hit, merged_requests, mshr_in_use,
		queue_slots, input ready);
	modport sink (input valid, access_addr, cache_hit, merged_requests, mshr_in_use,
		queue_slots, output ready);
endinterface

[hdl/mmrp_pf_if.sv]
// Prefetch request channel of the MSHR merge region prefetcher.
// Depends on mmrp_pkg for the field widths.
interface mmrp_pf_if;
	logic                          valid;
	logic                          ready;
	logic [mmrp_pkg::LINE_W-1:0]   prefetch_line;
	logic                          last_of_run;

	modport source (output valid, prefetch_line, last_of_run, input ready);
	modport sink (input valid, prefetch_line, last_of_run, output ready);
endinterface

[hdl/mmrp_ctrl.sv]
// Controller state machine of the MSHR merge region prefetcher.
// Depends on mmrp_pkg for the state, command and status types.
module mmrp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            evt_valid,
	output logic            evt_ready,
	output mmrp_pkg::cmd_t  cmd,
	input  mmrp_pkg::sts_t  sts
);

	mmrp_pkg::state_t state_q, state_n;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmrp_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			mmrp_pkg::ST_IDLE: begin
				if (evt_valid && sts.enabled) state_n = mmrp_pkg::ST_SCAN;
			end
			mmrp_pkg::ST_SCAN: begin
				if (sts.scan_done) state_n = mmrp_pkg::ST_COMMIT;
			end
			mmrp_pkg::ST_COMMIT: state_n = mmrp_pkg::ST_DIVIDE;
			mmrp_pkg::ST_DIVIDE: state_n = mmrp_pkg::ST_SIZE;
			mmrp_pkg::ST_SIZE:   state_n = mmrp_pkg::ST_EMIT;
			mmrp_pkg::ST_EMIT: begin
				if (sts.emit_done) state_n = mmrp_pkg::ST_IDLE;
			end
			default: state_n = mmrp_pkg::ST_IDLE;
		endcase
	end

	// Commands; a disabled event is taken and dropped in the idle state.
	always_comb begin
		cmd       = '0;
		evt_ready = 1'b0;
		unique case (state_q)
			mmrp_pkg::ST_IDLE: begin
				evt_ready = 1'b1;
				cmd.load  = evt_valid;
			end
			mmrp_pkg::ST_SCAN:   cmd.scan   = 1'b1;
			mmrp_pkg::ST_COMMIT: cmd.commit = 1'b1;
			mmrp_pkg::ST_DIVIDE: cmd.divide = 1'b1;
			mmrp_pkg::ST_SIZE:   cmd.size   = 1'b1;
			mmrp_pkg::ST_EMIT:   cmd.emit   = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

[hdl/mmrp_datapath.sv]
// Datapath of the MSHR merge region prefetcher: region table memory, scan, counters,
// run sizing and the output register. Depends on mmrp_pkg and mmrp_pf_if.
module mmrp_datapath #(
	parameter int unsigned TABLE_ENTRIES = mmrp_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned LINE_SHIFT    = mmrp_pkg::LINE_SHIFT_DEF,
	parameter int unsigned REGION_SHIFT  = mmrp_pkg::REGION_SHIFT_DEF,
	parameter int unsigned MAX_DEGREE    = mmrp_pkg::MAX_DEGREE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mmrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mmrp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [mmrp_pkg::ADDR_W-1:0]         access_addr,
	input  logic                                cache_hit,
	input  logic [mmrp_pkg::MERGE_W-1:0]        merged_requests,
	input  logic [mmrp_pkg::OCC_W-1:0]          mshr_in_use,
	input  logic [mmrp_pkg::SLOT_W-1:0]         queue_slots,
	input  mmrp_pkg::cmd_t                      cmd,
	output mmrp_pkg::sts_t                      sts,
	mmrp_pf_if.source                           pf
);

	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] LAST_PTR = CW'(TABLE_ENTRIES);
	localparam logic [mmrp_pkg::RUN_W-1:0] MAX_RUN = mmrp_pkg::RUN_W'(MAX_DEGREE);

	// Configuration registers.
	logic [mmrp_pkg::OCC_W-1:0] mshr_cap_q;
	logic                       enable_q;

	// Event registers.
	logic [mmrp_pkg::TAG_W-1:0]   tag_q;
	logic [mmrp_pkg::LINE_W-1:0]  line_q;
	logic                         hit_q;
	logic [mmrp_pkg::MERGE_W-1:0] merged_q;
	logic [mmrp_pkg::SLOT_W-1:0]  slots_q;
	logic [mmrp_pkg::QTR_W-1:0]   qtr_q;
	logic [mmrp_pkg::STAMP_W-1:0] clock_q;
	logic [mmrp_pkg::STAMP_W-1:0] now_q;

	// Table storage.
	mmrp_pkg::entry_t   mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	// Scan pipeline and results.
	logic [CW-1:0]      ptr_q;
	logic               rdv_s1;
	logic [IW-1:0]      idx_s1;
	mmrp_pkg::entry_t   rd_s1;
	logic               match_q;
	logic [IW-1:0]      match_idx_q;
	mmrp_pkg::entry_t   match_ent_q;
	logic               inv_found_q;
	logic [IW-1:0]      inv_idx_q;
	logic               have_best_q;
	logic [IW-1:0]      best_idx_q;
	logic [mmrp_pkg::STAMP_W-1:0] best_stamp_q;

	// Update and run sizing.
	mmrp_pkg::kind_t            kind_q;
	logic [mmrp_pkg::CNT_W-1:0] merge_new_q, hit_new_q, miss_new_q;
	logic [mmrp_pkg::QUOT_W-1:0] quot_q;
	logic [mmrp_pkg::RUN_W-1:0] run_q, cnt_q;
	logic                       ov_q;
	logic [mmrp_pkg::LINE_W-1:0] out_line_q;
	logic                       out_last_q;

	logic                       issue;
	logic                       mem_we;
	logic [IW-1:0]              wr_idx;
	mmrp_pkg::entry_t           wr_ent;
	mmrp_pkg::kind_t            kind_n;
	logic [mmrp_pkg::CNT_W:0]   merge_sum;
	logic [mmrp_pkg::CNT_W:0]   hit_sum, miss_sum;
	logic [mmrp_pkg::CNT_W-1:0] merge_sat, hit_sat, miss_sat;
	logic [32:0]                quot_prod;
	logic [mmrp_pkg::QUOT_W+1:0] scaled;
	logic [mmrp_pkg::QUOT_W-1:0] run_raw;
	logic [mmrp_pkg::RUN_W-1:0]  run_cap;
	logic [mmrp_pkg::CNT_W+2:0]  hit_x5;
	logic                        emit_go;
	logic [mmrp_pkg::ADDR_W-1:0] addr_line, addr_region;

	assign addr_line   = access_addr >> LINE_SHIFT;
	assign addr_region = access_addr >> REGION_SHIFT;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mshr_cap_q <= mmrp_pkg::MSHR_CAPACITY_RST;
			enable_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmrp_pkg::CFG_MSHR_CAPACITY:   mshr_cap_q <= cfg_data;
				mmrp_pkg::CFG_PREFETCH_ENABLE: enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Event capture and the event clock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
		end else if (cmd.load && enable_q) begin
			clock_q <= clock_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q    <= addr_region[mmrp_pkg::TAG_W-1:0];
			line_q   <= addr_line[mmrp_pkg::LINE_W-1:0];
			hit_q    <= cache_hit;
			merged_q <= merged_requests;
			slots_q  <= queue_slots;
			qtr_q    <= mmrp_pkg::throttle_quarters(mshr_in_use, mshr_cap_q);
			now_q    <= clock_q;
		end
	end

	// Table memory: one registered read port for the scan, one write port for the update.
	assign issue = cmd.scan && (ptr_q != LAST_PTR);

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_idx] <= wr_ent;
		if (issue)  rd_s1 <= mem[ptr_q[IW-1:0]];
	end

	// Scan control: one entry read per cycle, compared in the cycle after its read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			if (cmd.load)   ptr_q <= '0;
			else if (issue) ptr_q <= ptr_q + 1'b1;
			rdv_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) idx_s1 <= ptr_q[IW-1:0];
	end

	// Tag match, first free entry and oldest stamp, lowest index on a tie.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b0;
			inv_found_q <= 1'b0;
			have_best_q <= 1'b0;
		end else if (cmd.load) begin
			match_q     <= 1'b0;
			inv_found_q <= 1'b0;
			have_best_q <= 1'b0;
		end else if (rdv_s1) begin
			if (!valid_q[idx_s1]) begin
				if (!inv_found_q) begin
					inv_found_q <= 1'b1;
					inv_idx_q   <= idx_s1;
				end
			end else begin
				if (rd_s1.tag == tag_q) begin
					match_q     <= 1'b1;
					match_idx_q <= idx_s1;
					match_ent_q <= rd_s1;
				end
				if (!have_best_q || (best_stamp_q > rd_s1.stamp)) begin
					have_best_q  <= 1'b1;
					best_idx_q   <= idx_s1;
					best_stamp_q <= rd_s1.stamp;
				end
			end
		end
	end

	assign sts.enabled   = enable_q;
	assign sts.scan_done = (ptr_q == LAST_PTR) && !rdv_s1;
	assign sts.emit_done = (cnt_q == run_q);

	// Saturating counter updates for a known region.
	assign merge_sum = {1'b0, match_ent_q.merge_total} + (mmrp_pkg::CNT_W + 1)'(merged_q);
	assign hit_sum   = {1'b0, match_ent_q.hit_total} + 1'b1;
	assign miss_sum  = {1'b0, match_ent_q.miss_total} + 1'b1;
	assign merge_sat = merge_sum[mmrp_pkg::CNT_W] ? mmrp_pkg::CNT_MAX
		: merge_sum[mmrp_pkg::CNT_W-1:0];
	assign hit_sat   = hit_sum[mmrp_pkg::CNT_W] ? mmrp_pkg::CNT_MAX
		: hit_sum[mmrp_pkg::CNT_W-1:0];
	assign miss_sat  = miss_sum[mmrp_pkg::CNT_W] ? mmrp_pkg::CNT_MAX
		: miss_sum[mmrp_pkg::CNT_W-1:0];

	// Commit: allocate, refresh or count, and write the entry back.
	always_comb begin
		mem_we = 1'b0;
		wr_idx = match_idx_q;
		wr_ent = match_ent_q;
		kind_n = mmrp_pkg::KIND_NONE;
		if (cmd.commit) begin
			if (match_q) begin
				mem_we       = 1'b1;
				wr_ent.stamp = now_q;
				if (hit_q) begin
					wr_ent.hit_total = hit_sat;
				end else begin
					wr_ent.merge_total = merge_sat;
					wr_ent.miss_total  = miss_sat;
					kind_n             = mmrp_pkg::KIND_KNOWN_MISS;
				end
			end else if (!hit_q) begin
				mem_we = 1'b1;
				wr_idx = inv_found_q ? inv_idx_q : best_idx_q;
				wr_ent = '{tag: tag_q, stamp: now_q, merge_total: '0, hit_total: '0,
					miss_total: '0};
				kind_n = mmrp_pkg::KIND_NEW_MISS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			kind_q      <= kind_n;
			merge_new_q <= wr_ent.merge_total;
			hit_new_q   <= wr_ent.hit_total;
			miss_new_q  <= wr_ent.miss_total;
		end
	end

	// Merge total divided by 25.
	assign quot_prod = 33'(merge_new_q) * 33'(mmrp_pkg::DIV25_MUL);

	always_ff @(posedge clk) begin
		if (cmd.divide) quot_q <= quot_prod[mmrp_pkg::DIV25_SHIFT +: mmrp_pkg::QUOT_W];
	end

	// Run length, then the caps by queue slots and degree.
	assign scaled = (mmrp_pkg::QUOT_W + 2)'(quot_q) * (mmrp_pkg::QUOT_W + 2)'(qtr_q);
	assign hit_x5 = (mmrp_pkg::CNT_W + 3)'(hit_new_q) * (mmrp_pkg::CNT_W + 3)'(5);

	always_comb begin
		run_raw = '0;
		case (kind_q)
			mmrp_pkg::KIND_NEW_MISS: begin
				if (merged_q > mmrp_pkg::MERGE_ARM) run_raw = mmrp_pkg::QUOT_W'(qtr_q >> 1);
			end
			mmrp_pkg::KIND_KNOWN_MISS: begin
				if ((merge_new_q > mmrp_pkg::MERGE_LOW)
					&& (hit_x5 < (mmrp_pkg::CNT_W + 3)'(miss_new_q))) begin
					run_raw = '0;
				end else if (merge_new_q > mmrp_pkg::MERGE_HIGH) begin
					run_raw = scaled[mmrp_pkg::QUOT_W+1:2];
				end else if (merged_q > mmrp_pkg::MERGE_ARM) begin
					run_raw = mmrp_pkg::QUOT_W'(qtr_q);
				end
			end
			default: run_raw = '0;
		endcase
		run_cap = (run_raw > mmrp_pkg::QUOT_W'(slots_q)) ? slots_q
			: run_raw[mmrp_pkg::RUN_W-1:0];
		if (run_cap > MAX_RUN) run_cap = MAX_RUN;
	end

	// Emission counter and output register.
	assign emit_go = cmd.emit && (cnt_q != run_q) && (!ov_q || pf.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (cmd.size) begin
				run_q <= run_cap;
				cnt_q <= '0;
			end else if (emit_go) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit_go)        ov_q <= 1'b1;
			else if (pf.ready)  ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_line_q <= line_q + mmrp_pkg::LINE_W'(cnt_q) + 1'b1;
			out_last_q <= (cnt_q + 1'b1) == run_q;
		end
	end

	assign pf.valid         = ov_q;
	assign pf.prefetch_line = out_line_q;
	assign pf.last_of_run   = out_last_q;

	// The emission counter never passes the run length.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= run_q) else $error("emission counter beyond run length");

	// A sized run respects the queue slots and the degree limit.
	a_run_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.size |=> (run_q <= slots_q) && (run_q <= MAX_RUN))
		else $error("run exceeds its caps");

	// Entries are never invalidated once written.
	a_valid_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> $countones(valid_q) >= $past($countones(valid_q)))
		else $error("region table lost a valid entry");

endmodule

[hdl/mshr_merge_region_prefetcher_core.sv]
// Top level of the MSHR merge region prefetcher: controller plus datapath.
// Depends on mmrp_pkg, mmrp_evt_if, mmrp_pf_if, mmrp_ctrl and mmrp_datapath.
//
// Usage: training events arrive on the evt channel, prefetch words leave on the
// pf channel, one word per line of the run, the final one marked last_of_run.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, which the block itself does not enforce. One
// event at a time: the region table is scanned one entry per cycle through the
// single read port of the table memory, so the first word is valid after the
// scan, commit, divide and size states and the output register load, then one
// word per cycle while the receiver takes them. The next event can be taken
// once the controller is back in idle. A disabled event is taken and dropped.
// The output register lets the next event be taken while the last word waits.
// When the receiver stalls, emission pauses and the event channel stays closed
// until the last word of the run is loaded into the output register.
// Reset clears the valid bits, the event clock and the control state and sets
// the configuration to capacity 32, enabled; no clearing pass is needed.
module mshr_merge_region_prefetcher_core #(
	parameter int unsigned TABLE_ENTRIES = mmrp_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned LINE_SHIFT    = mmrp_pkg::LINE_SHIFT_DEF,
	parameter int unsigned REGION_SHIFT  = mmrp_pkg::REGION_SHIFT_DEF,
	parameter int unsigned MAX_DEGREE    = mmrp_pkg::MAX_DEGREE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mmrp_evt_if.sink                        evt,
	mmrp_pf_if.source                       pf,
	input  logic                            cfg_we,
	input  logic [mmrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mmrp_pkg::CFG_DATA_W-1:0] cfg_data
);

	mmrp_pkg::cmd_t cmd;
	mmrp_pkg::sts_t sts;
	logic           evt_ready;

	assign evt.ready = evt_ready;

	// Sequencing of scan, update, sizing and emission.
	mmrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Table, counters and output register.
	mmrp_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.LINE_SHIFT    (LINE_SHIFT),
		.REGION_SHIFT  (REGION_SHIFT),
		.MAX_DEGREE    (MAX_DEGREE)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.access_addr     (evt.access_addr),
		.cache_hit       (evt.cache_hit),
		.merged_requests (evt.merged_requests),
		.mshr_in_use     (evt.mshr_in_use),
		.queue_slots     (evt.queue_slots),
		.cmd             (cmd),
		.sts             (sts),
		.pf              (pf)
	);

endmodule
